>>> src/tcp_segment_checksum_macros.svh
// Assertion macros
`ifndef TCP_SEGMENT_CHECKSUM_MACROS_SVH
`define TCP_SEGMENT_CHECKSUM_MACROS_SVH

// same-cycle implication
`define TCS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcp_segment_checksum: same-cycle check failed");

// next-cycle implication
`define TCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcp_segment_checksum: next-cycle check failed");

`endif

>>> src/tcsum_pkg.sv
package tcsum_pkg;

  localparam int WORD_W = 16;
  localparam int SUM_W  = 32;

  // word positions in the IPv4 header
  localparam logic [WORD_W-1:0] IDX_VER_IHL   = 16'd0;
  localparam logic [WORD_W-1:0] IDX_TOT_LEN   = 16'd1;
  localparam logic [WORD_W-1:0] IDX_ADDR_FIRST = 16'd6;
  localparam logic [WORD_W-1:0] IDX_ADDR_LAST  = 16'd9;
  // TCP data offset word, counted from the end of the IP header
  localparam logic [WORD_W-1:0] TCP_OFF_WORD  = 16'd6;
  localparam logic [WORD_W-1:0] INDEX_MAX     = 16'hFFFF;

  localparam logic [3:0]  HDR_WORDS_MIN = 4'd5;
  localparam logic [6:0]  TCP_HDR_BYTES = 7'd20;
  localparam logic [SUM_W-1:0] PROTO_TCP = 32'd6;

  // packet totals handed from the accumulator to the fold stage
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [WORD_W-1:0] tcp_len;
    logic              err;
  } final_t;

endpackage

>>> src/tcsum_accum.sv
`include "tcp_segment_checksum_macros.svh"

module tcsum_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcsum_pkg::WORD_W-1:0] data_word,
  input  logic                         last_word,
  output logic                         fin_valid,
  input  logic                         fin_take,
  output tcsum_pkg::final_t            fin
);

  // input register
  logic                         v1;
  logic [tcsum_pkg::WORD_W-1:0] data1;
  logic                         last1;

  // per-packet state
  logic [tcsum_pkg::WORD_W-1:0] word_index;
  logic [tcsum_pkg::SUM_W-1:0]  sum_acc;
  logic [3:0]                   ip_header_words;
  logic [tcsum_pkg::WORD_W-1:0] packet_length;
  logic [3:0]                   tcp_offset_words;

  logic [tcsum_pkg::WORD_W-1:0] word_index_next;
  logic [tcsum_pkg::SUM_W-1:0]  sum_acc_next;
  logic [3:0]                   ihl_next;
  logic [tcsum_pkg::WORD_W-1:0] plen_next;
  logic [3:0]                   toff_next;

  logic [4:0]                   hdr_end;
  logic [17:0]                  byte_end;
  logic [17:0]                  plen_ext;
  logic [tcsum_pkg::WORD_W-1:0] add_addr;
  logic [tcsum_pkg::WORD_W-1:0] add_seg;
  logic [tcsum_pkg::WORD_W-1:0] tcp_len;
  logic [16:0]                  len_min;
  logic [16:0]                  words_need;
  logic [16:0]                  words_seen;
  logic                         err;
  logic                         consume;

  assign consume  = v1 && (!last1 || !fin_valid || fin_take);
  assign in_stall = v1 && !consume;

  always_comb begin
    ihl_next  = (word_index == tcsum_pkg::IDX_VER_IHL) ? data1[11:8] : ip_header_words;
    plen_next = (word_index == tcsum_pkg::IDX_TOT_LEN) ? data1 : packet_length;
    hdr_end   = {ihl_next, 1'b0};

    add_addr = '0;
    if (word_index >= tcsum_pkg::IDX_ADDR_FIRST && word_index <= tcsum_pkg::IDX_ADDR_LAST) begin
      add_addr = data1;
    end

    toff_next = tcp_offset_words;
    if (word_index == ({11'd0, hdr_end} + tcsum_pkg::TCP_OFF_WORD)) begin
      toff_next = data1[15:12];
    end

    // byte index of the low byte of this word
    byte_end = {1'b0, word_index, 1'b1};
    plen_ext = {2'b00, plen_next};
    add_seg  = '0;
    if (word_index >= {11'd0, hdr_end}) begin
      if (byte_end < plen_ext) begin
        add_seg = data1;
      end else if (byte_end == plen_ext) begin
        add_seg = {data1[15:8], 8'h00};  // odd tail, zero pad
      end
    end

    sum_acc_next = sum_acc + {16'd0, add_addr} + {16'd0, add_seg};
    word_index_next = (word_index == tcsum_pkg::INDEX_MAX) ? word_index
                                                           : word_index + 16'd1;

    tcp_len    = plen_next - {10'd0, ihl_next, 2'b00};
    len_min    = {11'd0, ihl_next, 2'b00} + {10'd0, tcsum_pkg::TCP_HDR_BYTES};
    words_need = ({1'b0, plen_next} + 17'd1) >> 1;
    words_seen = {1'b0, word_index} + 17'd1;

    err = (ihl_next < tcsum_pkg::HDR_WORDS_MIN)
       || ({1'b0, plen_next} < len_min)
       || (toff_next < tcsum_pkg::HDR_WORDS_MIN)
       || ({10'd0, toff_next, 2'b00} > tcp_len)
       || (words_seen < words_need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data1 <= data_word;
      last1 <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && last1)) begin
      word_index       <= '0;
      sum_acc          <= '0;
      ip_header_words  <= '0;
      packet_length    <= '0;
      tcp_offset_words <= '0;
    end else if (consume) begin
      word_index       <= word_index_next;
      sum_acc          <= sum_acc_next;
      ip_header_words  <= ihl_next;
      packet_length    <= plen_next;
      tcp_offset_words <= toff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= (fin_valid && !fin_take) || (consume && last1);
    end
  end

  always_ff @(posedge clk) begin
    if (consume && last1) begin
      fin.sum     <= sum_acc_next;
      fin.tcp_len <= tcp_len;
      fin.err     <= err;
    end
  end

  `TCS_ASSERT_NEXT(a_index_step, clk, rst, consume && !last1 && word_index != tcsum_pkg::INDEX_MAX, word_index == $past(word_index) + 16'd1)
  `TCS_ASSERT_NEXT(a_index_clear, clk, rst, consume && last1, word_index == '0 && sum_acc == '0)
  `TCS_ASSERT_NEXT(a_fin_hold, clk, rst, fin_valid && !fin_take, fin_valid && $stable(fin))

endmodule

>>> src/tcsum_fold.sv
module tcsum_fold (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fin_valid,
  output logic                         fin_take,
  input  tcsum_pkg::final_t            fin,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcsum_pkg::WORD_W-1:0] checksum,
  output logic                         header_error
);

  logic                        ready;
  logic [tcsum_pkg::SUM_W-1:0] s1;
  logic [16:0]                 s2;
  logic [16:0]                 s3;

  assign ready    = !out_valid || !out_stall;
  assign fin_take = fin_valid && ready;

  // pseudo-header protocol and length, then two end-around folds
  always_comb begin
    s1 = fin.sum + tcsum_pkg::PROTO_TCP + {16'd0, fin.tcp_len};
    s2 = {1'b0, s1[31:16]} + {1'b0, s1[15:0]};
    s3 = {16'd0, s2[16]} + {1'b0, s2[15:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      checksum     <= ~s3[15:0];
      header_error <= fin.err;
    end
  end

endmodule

>>> src/tcp_segment_checksum.sv
// Channel  Direction  Handshake           Word
// in       sink       in_valid/in_stall   data_word, last_word
// out      source     out_valid/out_stall checksum, header_error
//
// One packet word is taken every cycle while in_stall is low; a result passes
// through the input, totals and output registers after the last word of its
// packet is taken.
// Reset (rst, synchronous) empties all three registers and clears the
// per-packet state.
// out_stall holds the result; a new packet's words keep flowing until a
// second finished total meets a full output, then in_stall rises on its last word.
module tcp_segment_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] data_word,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] checksum,
  output logic        header_error
);

  // finished packet totals between the accumulator and the fold stage
  logic              fin_valid;
  logic              fin_take;
  tcsum_pkg::final_t fin;

  // header parse and ones' complement sum, one word per cycle while in_stall is low
  tcsum_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_word (data_word),
    .last_word (last_word),
    .fin_valid (fin_valid),
    .fin_take  (fin_take),
    .fin       (fin)
  );

  // pseudo-header length and protocol added, folded and inverted
  tcsum_fold u_fold (
    .clk          (clk),
    .rst          (rst),
    .fin_valid    (fin_valid),
    .fin_take     (fin_take),
    .fin          (fin),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .checksum     (checksum),
    .header_error (header_error)
  );

endmodule
